### src/uule_pkg.sv
`timescale 1ns / 1ps

package uule_pkg;

  // Default line length in bytes
  localparam int LineBytesDef = 45;

  // Widths that cover the whole line length range (up to 63 bytes)
  localparam int LEN_W = 6;
  localparam int PTR_W = 7;
  localparam int SUM_W = 16;
  localparam int CNT_W = 32;

  // Results per word are capped at this count
  localparam int MaxResults = 64;

  // Character codes
  localparam logic [6:0] CHAR_BQ = 7'd96;
  localparam logic [6:0] CHAR_SP = 7'd32;
  localparam logic [6:0] CHAR_NL = 7'd10;

  // One unit of work for the back end
  typedef struct packed {
    logic [LEN_W-1:0] len;    // data line length, zero for none
    logic             bank;   // line buffer bank that holds the data line
    logic             eof;    // add the zero-length line and close the file
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  // Back end hands a line buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Map a 6-bit value to its printable character
  function automatic logic [6:0] six_to_char(logic [5:0] v);
    logic [6:0] c;
    if (v == 6'd0) begin
      c = CHAR_BQ;
    end else begin
      c = {1'b0, v} + CHAR_SP;
    end
    return c;
  endfunction

endpackage

### src/uuencode_line_encoder.sv
// The first character of a line passes the queue, the back end state and output registers.
// One byte per cycle is taken into a line buffer while in_stall_o is low; the back end
//   sends one character per cycle while the output is not stalled, but stops to read
//   each 3-byte group from the line buffer before its four characters.
// Two line buffer banks and a two-entry queue let a line fill while the previous one drains.
// Reset (rst_ni, asynchronous, active low) clears counts, checksum and queue; no clearing pass.
`timescale 1ns / 1ps

module uuencode_line_encoder
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = LineBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             end_of_file_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [6:0]       out_char_o,
  output logic             last_of_run_o,
  output logic             file_done_o,
  output logic [SUM_W-1:0] checksum_o,
  output logic [CNT_W-1:0] byte_count_o
);

  localparam int AW = $clog2(2 * LINE_BYTES);

  logic          q_full, q_empty, push, pop;
  entry_t        push_entry, head;
  release_t      rel;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  uule_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .end_of_file_i(end_of_file_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry),
    .rel_i        (rel),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  uule_ram #(
    .WIDTH(8),
    .DEPTH(2 * LINE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  uule_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  uule_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (head),
    .pop_o        (pop),
    .rel_o        (rel),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o),
    .file_done_o  (file_done_o),
    .checksum_o   (checksum_o),
    .byte_count_o (byte_count_o)
  );

endmodule

### src/uule_ram.sv
`timescale 1ns / 1ps

module uule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/uule_front.sv
`timescale 1ns / 1ps

module uule_front
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = LineBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          has_byte_i,
  input  logic                          end_of_file_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output entry_t                        push_entry_o,
  input  release_t                      rel_i,
  output logic                          we_o,
  output logic [$clog2(2*LINE_BYTES)-1:0] waddr_o,
  output logic [7:0]                    wdata_o
);

  localparam int AW = $clog2(2 * LINE_BYTES);

  logic [LEN_W-1:0] fill_q, fill_d;
  logic             wr_bank_q, wr_bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             fire;
  logic [LEN_W-1:0] fill_after;
  logic             line_full;
  logic [LEN_W-1:0] line_len;
  logic             push_line;
  logic [SUM_W-1:0] sum_after;
  logic [CNT_W-1:0] count_after;
  logic [AW-1:0]    bank_base;

  // Hold input while the queue is full or the buffer being filled is still drained
  assign in_stall_o = q_full_i || busy_q[wr_bank_q];
  assign fire       = in_valid_i && !in_stall_o;

  // Classify the word
  always_comb begin
    fill_after  = has_byte_i ? fill_q + LEN_W'(1) : fill_q;
    line_full   = has_byte_i && (fill_after == LEN_W'(LINE_BYTES));
    line_len    = (line_full || end_of_file_i) ? fill_after : '0;
    sum_after   = has_byte_i ? ({sum_q[0], sum_q[SUM_W-1:1]} + SUM_W'(data_byte_i)) : sum_q;
    count_after = (has_byte_i && (count_q != '1)) ? count_q + CNT_W'(1) : count_q;
  end

  assign push_o    = fire && (line_full || end_of_file_i);
  assign push_line = push_o && (line_len != '0);

  assign push_entry_o.len   = line_len;
  assign push_entry_o.bank  = wr_bank_q;
  assign push_entry_o.eof   = end_of_file_i;
  assign push_entry_o.sum   = sum_after;
  assign push_entry_o.count = count_after;

  // Store the byte in the current bank
  assign bank_base = wr_bank_q ? AW'(LINE_BYTES) : '0;
  assign we_o      = fire && has_byte_i;
  assign waddr_o   = bank_base + AW'(fill_q);
  assign wdata_o   = data_byte_i;

  // Advance fill, bank, checksum and count
  always_comb begin
    fill_d    = fill_q;
    wr_bank_d = wr_bank_q;
    sum_d     = sum_q;
    count_d   = count_q;
    busy_d    = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (fire) begin
      fill_d  = (line_full || end_of_file_i) ? '0 : fill_after;
      sum_d   = end_of_file_i ? '0 : sum_after;
      count_d = end_of_file_i ? '0 : count_after;
      if (push_line) begin
        busy_d[wr_bank_q] = 1'b1;
        wr_bank_d         = !wr_bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
      sum_q     <= '0;
      count_q   <= '0;
    end else begin
      fill_q    <= fill_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
    end
  end

`ifndef SYNTH
  // A bank comes back only after it was handed out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("uule_front: release of a bank that is not busy");

  // The fill position never reaches the line length between words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < LEN_W'(LINE_BYTES))
    else $error("uule_front: fill count out of range");
`endif

endmodule

### src/uule_queue.sv
`timescale 1ns / 1ps

module uule_queue
  import uule_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t     slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slots_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("uule_queue: push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("uule_queue: pop while empty");
`endif

endmodule

### src/uule_back.sv
`timescale 1ns / 1ps

module uule_back
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = LineBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  entry_t                          q_head_i,
  output logic                            pop_o,
  output release_t                        rel_o,
  output logic                            re_o,
  output logic [$clog2(2*LINE_BYTES)-1:0] raddr_o,
  input  logic [7:0]                      rdata_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [6:0]                      out_char_o,
  output logic                            last_of_run_o,
  output logic                            file_done_o,
  output logic [SUM_W-1:0]                checksum_o,
  output logic [CNT_W-1:0]                byte_count_o
);

  localparam int AW    = $clog2(2 * LINE_BYTES);
  localparam int EMT_W = $clog2(MaxResults);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LEN   = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_CHARS = 7'b0001000,
    ST_NL    = 7'b0010000,
    ST_ZLEN  = 7'b0100000,
    ST_ZNL   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  entry_t           cur_q, cur_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [1:0]       step_q, step_d;
  logic [7:0]       grp_q [3];
  logic             rd_ok_q;
  logic [EMT_W-1:0] emit_cnt_q, emit_cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [6:0]       out_char_q;
  logic             out_last_q, out_done_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [CNT_W-1:0] out_cnt_q;

  logic             slot_free;
  logic             emitting;
  logic             emit;
  logic [6:0]       ch;
  logic             seq_last;
  logic             cap_hit;
  logic             finish;
  logic [PTR_W-1:0] rd_idx;
  logic             rd_in;
  logic [PTR_W-1:0] next_ptr;
  logic [5:0]       six;
  logic [AW-1:0]    bank_base;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Read one byte of the current group per cycle
  assign rd_idx    = ptr_q + PTR_W'(step_q);
  assign rd_in     = (state_q == ST_FETCH) && (step_q != 2'd3) &&
                     (rd_idx < PTR_W'(cur_q.len));
  assign bank_base = cur_q.bank ? AW'(LINE_BYTES) : '0;
  assign re_o      = rd_in;
  assign raddr_o   = bank_base + AW'(rd_idx);
  assign next_ptr  = ptr_q + PTR_W'(3);

  // Pick the 6-bit value of the current group character
  always_comb begin
    case (step_q)
      2'd0:    six = grp_q[0][7:2];
      2'd1:    six = {grp_q[0][1:0], grp_q[1][7:4]};
      2'd2:    six = {grp_q[1][3:0], grp_q[2][7:6]};
      default: six = grp_q[2][5:0];
    endcase
  end

  // Character of the current state
  always_comb begin
    emitting = 1'b1;
    seq_last = 1'b0;
    case (state_q)
      ST_LEN:   ch = six_to_char(6'(cur_q.len));
      ST_CHARS: ch = six_to_char(six);
      ST_NL: begin
        ch       = CHAR_NL;
        seq_last = !cur_q.eof;
      end
      ST_ZLEN:  ch = CHAR_BQ;
      ST_ZNL: begin
        ch       = CHAR_NL;
        seq_last = 1'b1;
      end
      default: begin
        ch       = CHAR_NL;
        emitting = 1'b0;
      end
    endcase
  end

  assign emit      = emitting && slot_free;
  assign cap_hit   = (emit_cnt_q == EMT_W'(MaxResults - 1));
  assign finish    = emit && (seq_last || cap_hit);
  assign pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign rel_o.valid = finish && (cur_q.len != '0);
  assign rel_o.bank  = cur_q.bank;

  // Sequence the line characters
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    ptr_d      = ptr_q;
    step_d     = step_q;
    emit_cnt_d = emit ? emit_cnt_q + EMT_W'(1) : emit_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          cur_d      = q_head_i;
          ptr_d      = '0;
          step_d     = '0;
          emit_cnt_d = '0;
          state_d    = (q_head_i.len != '0) ? ST_LEN : ST_ZLEN;
        end
      end
      ST_LEN: begin
        if (emit) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (step_q == 2'd3) begin
          step_d  = '0;
          state_d = ST_CHARS;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_CHARS: begin
        if (emit) begin
          if (step_q == 2'd3) begin
            step_d  = '0;
            ptr_d   = next_ptr;
            state_d = (next_ptr >= PTR_W'(cur_q.len)) ? ST_NL : ST_FETCH;
          end else begin
            step_d = step_q + 2'd1;
          end
        end
      end
      ST_NL: begin
        if (emit) begin
          state_d = ST_ZLEN;
        end
      end
      ST_ZLEN: begin
        if (emit) begin
          state_d = ST_ZNL;
        end
      end
      ST_ZNL: begin
        state_d = state_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (finish) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the entry, pointers and group bytes
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    ptr_q      <= ptr_d;
    step_q     <= step_d;
    emit_cnt_q <= emit_cnt_d;
    if (state_q == ST_FETCH) begin
      rd_ok_q <= rd_in;
      case (step_q)
        2'd1:    grp_q[0] <= rd_ok_q ? rdata_i : 8'd0;
        2'd2:    grp_q[1] <= rd_ok_q ? rdata_i : 8'd0;
        2'd3:    grp_q[2] <= rd_ok_q ? rdata_i : 8'd0;
        default: ;
      endcase
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= ch;
      out_last_q <= seq_last || cap_hit;
      out_done_q <= cur_q.eof && (seq_last || cap_hit);
      out_sum_q  <= cur_q.sum;
      out_cnt_q  <= cur_q.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;
  assign file_done_o   = out_done_q;
  assign checksum_o    = out_sum_q;
  assign byte_count_o  = out_cnt_q;

`ifndef SYNTH
  // The end of the file closes the run of its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && file_done_o) |-> last_of_run_o)
    else $error("uule_back: file end without end of run");

  // A word with no data line never reads the line buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    re_o |-> (cur_q.len != '0))
    else $error("uule_back: buffer read for an empty line");
`endif

endmodule

### tb/sv/uuencode_line_encoder_tb.sv
`timescale 1ns / 1ps

module uuencode_line_encoder_tb;
  import uule_pkg::*;

  localparam int LINE_LEN     = LineBytesDef;
  localparam int STORE_MAX    = 63;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 270;
  localparam int MAX_SHOWN    = 10;
  localparam int TAIL_CYCLES  = 20;

  // One encoded character as it leaves the block
  typedef struct packed {
    logic [6:0]       ch;
    logic             last;
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } enc_char_t;

  // One stimulus word; typed rows carry their characters, listed last to first
  typedef struct packed {
    logic [7:0]       data;
    logic             has;
    logic             eof;
    logic             typed;
    logic [3:0]       n;
    logic [7:0][6:0]  chars;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       data_byte_i;
  logic             has_byte_i;
  logic             end_of_file_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [6:0]       out_char_o;
  logic             last_of_run_o;
  logic             file_done_o;
  logic [SUM_W-1:0] checksum_o;
  logic [CNT_W-1:0] byte_count_o;

  uuencode_line_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o),
    .file_done_o   (file_done_o),
    .checksum_o    (checksum_o),
    .byte_count_o  (byte_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Encoder shadow state
  logic [7:0]       line_buf [STORE_MAX];
  int unsigned      line_fill = 0;
  logic [SUM_W-1:0] sum_q = '0;
  logic [CNT_W-1:0] count_q = '0;

  enc_char_t item_chars [$];
  enc_char_t expected_chars [$];
  stim_row_t dir_rows [$];
  stim_row_t cur_row;

  int  in_accepts = 0;
  int  out_accepts = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  hold_asked = 0;
  bit  tx_burst = 1'b0;

  function automatic logic [6:0] map6(logic [5:0] v);
    return (v == 6'd0) ? CHAR_BQ : ({1'b0, v} + CHAR_SP);
  endfunction

  // Append one character, capped per word
  function automatic void put_char(logic [6:0] c);
    enc_char_t e;
    if (item_chars.size() < MaxResults) begin
      e.ch    = c;
      e.last  = 1'b0;
      e.done  = 1'b0;
      e.sum   = sum_q;
      e.count = count_q;
      item_chars.push_back(e);
    end
  endfunction

  // Read a held byte; missing bytes of a short group read as zero
  function automatic logic [7:0] held(int unsigned i);
    return (i < line_fill && i < STORE_MAX) ? line_buf[i] : 8'h00;
  endfunction

  // Emit the held line: length, groups of four, newline
  function automatic void flush_line();
    logic [7:0]  a, b, c;
    int unsigned i;
    put_char(map6(6'(line_fill)));
    for (i = 0; i < line_fill; i += 3) begin
      a = held(i);
      b = held(i + 1);
      c = held(i + 2);
      put_char(map6(a[7:2]));
      put_char(map6({a[1:0], b[7:4]}));
      put_char(map6({b[3:0], c[7:6]}));
      put_char(map6(c[5:0]));
    end
    put_char(CHAR_NL);
    line_fill = 0;
  endfunction

  // Work out the characters that one accepted word causes
  function automatic void encode_item(logic [7:0] data, logic has, logic eof);
    enc_char_t e;
    item_chars.delete();
    if (has) begin
      if (line_fill < STORE_MAX) line_buf[line_fill] = data;
      line_fill++;
      sum_q = {sum_q[0], sum_q[SUM_W-1:1]} + SUM_W'(data);
      if (count_q != '1) count_q++;
      if (line_fill >= LINE_LEN) flush_line();
    end
    if (eof) begin
      if (line_fill > 0) flush_line();
      flush_line();
      e = item_chars[item_chars.size() - 1];
      e.done = 1'b1;
      item_chars[item_chars.size() - 1] = e;
      line_fill = 0;
      sum_q = '0;
      count_q = '0;
    end
    if (item_chars.size() > 0) begin
      e = item_chars[item_chars.size() - 1];
      e.last = 1'b1;
      item_chars[item_chars.size() - 1] = e;
    end
  endfunction

  // Compare one output word with the oldest expectation
  function automatic void check_char();
    enc_char_t want;
    if (expected_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("unexpected char %0d last %0b done %0b sum %h count %0d",
                 out_char_o, last_of_run_o, file_done_o, checksum_o, byte_count_o);
    end else begin
      want = expected_chars.pop_front();
      if (out_char_o !== want.ch || last_of_run_o !== want.last ||
          file_done_o !== want.done || checksum_o !== want.sum ||
          byte_count_o !== want.count) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("char mismatch: exp %0d/%0b/%0b/%h/%0d got %0d/%0b/%0b/%h/%0d",
                   want.ch, want.last, want.done, want.sum, want.count,
                   out_char_o, last_of_run_o, file_done_o, checksum_o, byte_count_o);
      end
    end
  endfunction

  // Track accepted words on both sides
  always @(posedge clk_i) begin
    enc_char_t e;
    int        i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        encode_item(data_byte_i, has_byte_i, end_of_file_i);
        // typed rows replace the computed characters with the written ones
        if (cur_row.typed) begin
          item_chars.delete();
          for (i = 0; i < cur_row.n; i++) begin
            e.ch    = cur_row.chars[i];
            e.last  = (i == cur_row.n - 1);
            e.done  = cur_row.eof && (i == cur_row.n - 1);
            e.sum   = cur_row.sum;
            e.count = cur_row.count;
            item_chars.push_back(e);
          end
        end
        foreach (item_chars[k]) expected_chars.push_back(item_chars[k]);
        in_accepts++;
      end
      if (out_valid_o && !out_stall_i) begin
        check_char();
        out_accepts++;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a word", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic stim_row_t plain(logic [7:0] data, logic has, logic eof);
    stim_row_t r;
    r = '0;
    r.data = data;
    r.has  = has;
    r.eof  = eof;
    return r;
  endfunction

  function automatic stim_row_t known(logic [7:0] data, logic has, logic eof,
                                      logic [3:0] n, logic [7:0][6:0] chars,
                                      logic [SUM_W-1:0] sum, logic [CNT_W-1:0] count);
    stim_row_t r;
    r       = plain(data, has, eof);
    r.typed = 1'b1;
    r.n     = n;
    r.chars = chars;
    r.sum   = sum;
    r.count = count;
    return r;
  endfunction

  // Offer one word, after a random gap outside bursts, and hold it until taken
  task automatic offer(stim_row_t r);
    int gap;
    int target;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_row       = r;
    data_byte_i   = r.data;
    has_byte_i    = r.has;
    end_of_file_i = r.eof;
    in_valid_i    = 1'b1;
    target = in_accepts + 1;
    do @(negedge clk_i); while (in_accepts != target);
  endtask

  // Stop offering until every expected character has come
  task automatic wait_drained();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (expected_chars.size() != 0);
  endtask

  // Receiver: random stall per word, one long hold on request
  initial begin
    int  n;
    int  seen;
    int  holds_done;
    bit  rx_burst;
    holds_done  = 0;
    rx_burst    = 1'b0;
    out_stall_i = 1'b0;
    do @(negedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        n = HOLD_CYCLES;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      seen = out_accepts;
      do @(negedge clk_i); while (out_accepts == seen);
    end
  end

  // Sender: directed table, then random files
  initial begin
    int items;
    int files;
    int len;
    int b;
    bit eof_on_byte;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    has_byte_i    = 1'b0;
    end_of_file_i = 1'b0;
    cur_row       = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // word with neither byte nor end: no characters
    dir_rows.push_back(known(8'hFF, 1'b0, 1'b0, 4'd0, '0, '0, '0));
    // end with no byte: only the zero-length line, data ignored
    dir_rows.push_back(known(8'h5A, 1'b0, 1'b1, 4'd2, 56'({CHAR_NL, CHAR_BQ}), '0, '0));
    // lone zero byte ending the file: every six-bit value is zero
    dir_rows.push_back(known(8'h00, 1'b1, 1'b1, 4'd8,
                             {CHAR_NL, CHAR_BQ, CHAR_NL, CHAR_BQ, CHAR_BQ, CHAR_BQ,
                              CHAR_BQ, 7'd33}, 16'h0000, 32'd1));
    // lone all-ones byte ending the file, short group padded with zeros
    dir_rows.push_back(known(8'hFF, 1'b1, 1'b1, 4'd8,
                             {CHAR_NL, CHAR_BQ, CHAR_NL, CHAR_BQ, CHAR_BQ, 7'd80,
                              7'd95, 7'd33}, 16'h00FF, 32'd1));
    // full group, end marker apart
    dir_rows.push_back(plain(8'h4D, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h61, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h6E, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h00, 1'b0, 1'b1));
    // one-byte file
    dir_rows.push_back(plain(8'hA5, 1'b1, 1'b1));
    // two-byte file with an ignored word inside
    dir_rows.push_back(plain(8'h12, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hFF, 1'b0, 1'b0));
    dir_rows.push_back(plain(8'h34, 1'b1, 1'b1));
    // sign-bit and edge bytes across two groups
    dir_rows.push_back(plain(8'h80, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h7F, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h01, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hFE, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'h55, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hAA, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hFF, 1'b0, 1'b1));
    // all-ones group, end on its last byte
    dir_rows.push_back(plain(8'hFF, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hFF, 1'b1, 1'b0));
    dir_rows.push_back(plain(8'hFF, 1'b1, 1'b1));

    foreach (dir_rows[k]) offer(dir_rows[k]);

    // Random files; lengths lean toward small files and line boundaries
    items = 0;
    files = 0;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0, 1:    len = $urandom_range(0, 8);
        2:       len = LINE_LEN * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
        default: len = $urandom_range(0, 2 * LINE_LEN + 5);
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      // fill the block while the receiver holds off
      if (files == 2) begin
        len = 3 * LINE_LEN;
        tx_burst = 1'b1;
        hold_asked++;
      end
      if (files == 4) wait_drained();
      eof_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (b = 0; b < len; b++) begin
        if ($urandom_range(0, 9) == 0) begin
          offer(plain(8'($urandom), 1'b0, 1'b0));
          items++;
        end
        offer(plain(8'($urandom), 1'b1, eof_on_byte && (b == len - 1)));
        items++;
      end
      if (!eof_on_byte) begin
        offer(plain(8'($urandom), 1'b0, 1'b1));
        items++;
      end
      files++;
    end

    // Drain, then let the pipeline idle before the final check
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_chars.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
src/uule_pkg.sv
src/uule_ram.sv
src/uule_front.sv
src/uule_queue.sv
src/uule_back.sv
src/uuencode_line_encoder.sv
tb/sv/uuencode_line_encoder_tb.sv
